### rtl/core/wbs_pkg.sv
// ----------------------------------------------------------------------------
// Windowed bitmap set package
// Shared types, codes and a helper function for the windowed bitmap set.
// ----------------------------------------------------------------------------
package wbs_pkg;

    localparam int WORDS_DEF = 16;
    localparam int KEY_W     = 32;
    localparam int WBW       = 26;
    localparam int DW        = 28;
    localparam int BIT_W     = 6;
    localparam int WORD_W    = 64;

    typedef enum logic [2:0] {
        OP_ADD       = 3'd0,
        OP_REMOVE    = 3'd1,
        OP_TEST      = 3'd2,
        OP_IS_EMPTY  = 3'd3,
        OP_FIND_NEXT = 3'd4,
        OP_CLEAR     = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ERROR    = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PLAN,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FILL,
        S_RMW_RD,
        S_RMW_WR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FOUND,
        S_DONE
    } t_state;

    typedef struct packed {
        logic          has;
        logic          below;
        logic          above;
        logic          in_win;
        logic          ok_down;
        logic          ok_up;
        logic [DW-1:0] off;
        logic [DW-1:0] cnt_down;
        logic [DW-1:0] cnt_up;
    } t_win;

    function automatic logic [BIT_W-1:0] ctz64(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] v;
        logic [BIT_W-1:0]  n;
        v = w;
        n = '0;
        if (v[31:0] == 32'd0) begin
            n[5] = 1'b1;
            v    = v >> 32;
        end
        if (v[15:0] == 16'd0) begin
            n[4] = 1'b1;
            v    = v >> 16;
        end
        if (v[7:0] == 8'd0) begin
            n[3] = 1'b1;
            v    = v >> 8;
        end
        if (v[3:0] == 4'd0) begin
            n[2] = 1'b1;
            v    = v >> 4;
        end
        if (v[1:0] == 2'd0) begin
            n[1] = 1'b1;
            v    = v >> 2;
        end
        if (v[0] == 1'b0) begin
            n[0] = 1'b1;
        end
        return n;
    endfunction

endpackage

### rtl/core/wbs_ram.sv
// ----------------------------------------------------------------------------
// Windowed bitmap set word memory
// Simple dual-port memory of 64-bit bitmap words with a registered read.
// ----------------------------------------------------------------------------
module wbs_ram #(
    parameter int WORDS = wbs_pkg::WORDS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] i_waddr,
    input  logic [wbs_pkg::WORD_W-1:0]       i_wdata,
    input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] i_raddr,
    output logic [wbs_pkg::WORD_W-1:0]       o_rdata
);
    import wbs_pkg::*;

    logic [WORD_W-1:0] mem [WORDS];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/wbs_win.sv
// ----------------------------------------------------------------------------
// Windowed bitmap set window arithmetic
// Places a key against the current window in word units and works out the
// word counts needed to grow the window downwards or upwards.
// ----------------------------------------------------------------------------
module wbs_win #(
    parameter int WORDS = wbs_pkg::WORDS_DEF
) (
    input  logic signed [wbs_pkg::WBW-1:0]   i_kw,
    input  logic signed [wbs_pkg::WBW-1:0]   i_bw,
    input  logic [$clog2(WORDS+1)-1:0]       i_cnt,
    output wbs_pkg::t_win                    o_win
);
    import wbs_pkg::*;

    localparam int CW = $clog2(WORDS + 1);
    localparam logic signed [DW-1:0] ONE     = DW'(1);
    localparam logic signed [DW-1:0] WORDS_X = DW'(WORDS);

    logic signed [DW-1:0] kw_x;
    logic signed [DW-1:0] bw_x;
    logic signed [DW-1:0] cnt_x;
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] dn;
    logic signed [DW-1:0] up;

    always_comb begin
        kw_x  = {{(DW-WBW){i_kw[WBW-1]}}, i_kw};
        bw_x  = {{(DW-WBW){i_bw[WBW-1]}}, i_bw};
        cnt_x = {{(DW-CW){1'b0}}, i_cnt};
        d     = kw_x - bw_x;
        dn    = cnt_x - d;
        up    = d + ONE;

        o_win.has      = (i_cnt != '0);
        o_win.below    = d[DW-1];
        o_win.above    = (d >= cnt_x);
        o_win.in_win   = (i_cnt != '0) && !d[DW-1] && (d < cnt_x);
        o_win.ok_down  = (dn <= WORDS_X);
        o_win.ok_up    = (up <= WORDS_X);
        o_win.off      = d;
        o_win.cnt_down = dn;
        o_win.cnt_up   = up;
    end

endmodule

### rtl/core/wbs_seq.sv
// ----------------------------------------------------------------------------
// Windowed bitmap set sequencer
// Runs each transaction as a sequence of single-word memory accesses: word
// moves and zero fills when the window grows, a read-modify-write of the
// addressed word, or a scan over the words of the window.
// ----------------------------------------------------------------------------
module wbs_seq #(
    parameter int WORDS = wbs_pkg::WORDS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [2:0]                       i_op,
    input  logic signed [wbs_pkg::KEY_W-1:0] i_key,
    output logic                             o_busy,
    output logic                             o_valid,
    output logic [1:0]                       o_status,
    output logic                             o_answer,
    output logic signed [wbs_pkg::KEY_W-1:0] o_found_key,
    output logic                             o_we,
    output logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] o_waddr,
    output logic [wbs_pkg::WORD_W-1:0]       o_wdata,
    output logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] o_raddr,
    input  logic [wbs_pkg::WORD_W-1:0]       i_rdata
);
    import wbs_pkg::*;

    localparam int IW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW = $clog2(WORDS + 1);

    t_state                   r_state, n_state;
    t_op                      r_op, n_op;
    logic [KEY_W-1:0]         r_key, n_key;
    t_win                     r_dec, n_dec;
    logic signed [WBW-1:0]    r_bw, n_bw;
    logic [CW-1:0]            r_cnt, n_cnt;
    logic [IW-1:0]            r_i, n_i;
    logic [IW-1:0]            r_last, n_last;
    logic [IW-1:0]            r_shift, n_shift;
    logic [IW-1:0]            r_off, n_off;
    logic [WORD_W-1:0]        r_mask, n_mask;
    logic [WORD_W-1:0]        r_word, n_word;
    t_status                  r_status, n_status;
    logic                     r_answer, n_answer;
    logic [KEY_W-1:0]         r_found, n_found;

    logic signed [WBW-1:0]    kw;
    t_win                     win;
    logic [WORD_W-1:0]        bit_sel;
    logic [WORD_W-1:0]        scan_word;
    logic                     scan_last;
    logic [WBW-1:0]           found_word;

    assign kw         = r_key[KEY_W-1:BIT_W];
    assign bit_sel    = {{(WORD_W-1){1'b0}}, 1'b1} << r_key[BIT_W-1:0];
    assign scan_word  = i_rdata & r_mask;
    assign scan_last  = ((CW'(r_i) + CW'(1)) == r_cnt);
    assign found_word = r_bw + WBW'(r_i);

    wbs_win #(
        .WORDS (WORDS)
    ) u_win (
        .i_kw  (kw),
        .i_bw  (r_bw),
        .i_cnt (r_cnt),
        .o_win (win)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: n_state = S_PLAN;
            S_PLAN: begin
                unique case (r_op)
                    OP_ADD: begin
                        priority if (!r_dec.has) begin
                            n_state = S_FILL;
                        end else if (r_dec.below) begin
                            n_state = r_dec.ok_down ? S_SHIFT_RD : S_DONE;
                        end else if (r_dec.above) begin
                            n_state = r_dec.ok_up ? S_FILL : S_DONE;
                        end else begin
                            n_state = S_RMW_RD;
                        end
                    end
                    OP_REMOVE, OP_TEST: n_state = r_dec.in_win ? S_RMW_RD : S_DONE;
                    OP_IS_EMPTY:        n_state = r_dec.has ? S_SCAN_RD : S_DONE;
                    OP_FIND_NEXT: begin
                        n_state = (r_dec.has && !r_dec.above) ? S_SCAN_RD : S_DONE;
                    end
                    default:            n_state = S_DONE;
                endcase
            end
            S_SHIFT_RD: n_state = S_SHIFT_WR;
            S_SHIFT_WR: begin
                if (r_i == '0) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (r_i == r_last) begin
                    n_state = S_RMW_RD;
                end
            end
            S_RMW_RD:  n_state = S_RMW_WR;
            S_RMW_WR:  n_state = S_DONE;
            S_SCAN_RD: n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                priority if (scan_word != '0) begin
                    n_state = (r_op == OP_FIND_NEXT) ? S_FOUND : S_DONE;
                end else if (scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_FOUND: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_op     = r_op;
        n_key    = r_key;
        n_dec    = r_dec;
        n_bw     = r_bw;
        n_cnt    = r_cnt;
        n_i      = r_i;
        n_last   = r_last;
        n_shift  = r_shift;
        n_off    = r_off;
        n_mask   = r_mask;
        n_word   = r_word;
        n_status = r_status;
        n_answer = r_answer;
        n_found  = r_found;
        o_we     = 1'b0;
        o_waddr  = r_i;
        o_wdata  = '0;
        o_raddr  = r_i;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op  = t_op'(i_op);
                    n_key = i_key;
                end
            end
            S_DECODE: n_dec = win;
            S_PLAN: begin
                n_status = ST_OK;
                n_answer = 1'b0;
                n_found  = '0;
                n_mask   = '1;
                unique case (r_op)
                    OP_ADD: begin
                        priority if (!r_dec.has) begin
                            n_bw   = kw;
                            n_cnt  = CW'(1);
                            n_i    = '0;
                            n_last = '0;
                            n_off  = '0;
                        end else if (r_dec.below) begin
                            if (r_dec.ok_down) begin
                                n_shift = IW'(r_dec.cnt_down[CW-1:0] - r_cnt);
                                n_last  = IW'(r_dec.cnt_down[CW-1:0] - r_cnt - CW'(1));
                                n_i     = IW'(r_cnt - CW'(1));
                                n_bw    = kw;
                                n_cnt   = r_dec.cnt_down[CW-1:0];
                                n_off   = '0;
                            end else begin
                                n_status = ST_OVERFLOW;
                            end
                        end else if (r_dec.above) begin
                            if (r_dec.ok_up) begin
                                n_i    = r_cnt[IW-1:0];
                                n_last = r_dec.off[IW-1:0];
                                n_cnt  = r_dec.cnt_up[CW-1:0];
                                n_off  = r_dec.off[IW-1:0];
                            end else begin
                                n_status = ST_OVERFLOW;
                            end
                        end else begin
                            n_off = r_dec.off[IW-1:0];
                        end
                    end
                    OP_REMOVE: begin
                        n_off = r_dec.off[IW-1:0];
                        if (!r_dec.in_win) begin
                            n_status = ST_ERROR;
                        end
                    end
                    OP_TEST: n_off = r_dec.off[IW-1:0];
                    OP_IS_EMPTY: begin
                        n_i      = '0;
                        n_answer = !r_dec.has;
                    end
                    OP_FIND_NEXT: begin
                        if (r_dec.below) begin
                            n_i = '0;
                        end else begin
                            n_i    = r_dec.off[IW-1:0];
                            n_mask = {WORD_W{1'b1}} << r_key[BIT_W-1:0];
                        end
                    end
                    OP_CLEAR: begin
                        n_cnt = '0;
                        n_bw  = '0;
                    end
                    default: n_status = ST_ERROR;
                endcase
            end
            S_SHIFT_RD: o_raddr = r_i;
            S_SHIFT_WR: begin
                o_we    = 1'b1;
                o_waddr = r_i + r_shift;
                o_wdata = i_rdata;
                o_raddr = r_i - IW'(1);
                n_i     = (r_i == '0) ? '0 : r_i - IW'(1);
            end
            S_FILL: begin
                o_we    = 1'b1;
                o_waddr = r_i;
                o_wdata = '0;
                n_i     = r_i + IW'(1);
            end
            S_RMW_RD: o_raddr = r_off;
            S_RMW_WR: begin
                o_waddr = r_off;
                unique case (r_op)
                    OP_ADD: begin
                        o_we    = 1'b1;
                        o_wdata = i_rdata | bit_sel;
                    end
                    OP_REMOVE: begin
                        o_we    = 1'b1;
                        o_wdata = i_rdata & ~bit_sel;
                    end
                    default: n_answer = |(i_rdata & bit_sel);
                endcase
            end
            S_SCAN_RD: o_raddr = r_i;
            S_SCAN_CHK: begin
                n_mask = '1;
                priority if (scan_word != '0) begin
                    n_word   = scan_word;
                    n_answer = 1'b0;
                end else if (scan_last) begin
                    n_answer = (r_op == OP_IS_EMPTY);
                end else begin
                    o_raddr = r_i + IW'(1);
                    n_i     = r_i + IW'(1);
                end
            end
            S_FOUND: begin
                n_answer = 1'b1;
                n_found  = {found_word, ctz64(r_word)};
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bw    <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_bw    <= n_bw;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_dec    <= n_dec;
        r_i      <= n_i;
        r_last   <= n_last;
        r_shift  <= n_shift;
        r_off    <= n_off;
        r_mask   <= n_mask;
        r_word   <= n_word;
        r_status <= n_status;
        r_answer <= n_answer;
        r_found  <= n_found;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_valid     = (r_state == S_DONE);
    assign o_status    = r_status;
    assign o_answer    = r_answer;
    assign o_found_key = r_found;

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("Result strobe held for more than one cycle.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(WORDS))
        else $error("Window word count exceeds the memory depth.");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("Accepted transaction did not raise busy.");

    a_write_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (CW'(o_waddr) < r_cnt))
        else $error("Memory write outside the window.");

    a_rmw_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW_WR) |-> (CW'(r_off) < r_cnt))
        else $error("Read-modify-write index outside the window.");

endmodule

### rtl/core/windowed_bitmap_set.sv
// ----------------------------------------------------------------------------
// Windowed bitmap set
// Set of signed 32-bit keys held as a bitmap over a window of 64-bit words.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low; busy then
// stays high until the result has been shown on o_valid for its single cycle,
// and the receiver cannot hold the result off. Memory accesses go through the
// one word memory, one word per cycle. After acceptance the sequencer decodes
// and plans; clear, invalid codes, refused adds and out-of-window cases then
// go to the strobe. Inside the window, add, remove or test read the addressed
// word, and add or remove write it back. Add that opens a window or extends
// it upwards zero-fills the new words; add that grows it downwards moves the
// held words up, then zero-fills the new low words. Is_empty and find_next
// scan words up to the first set bit, and find_next then forms the found key.
// A new transaction can be accepted from the cycle after the strobe.
// ----------------------------------------------------------------------------
module windowed_bitmap_set #(
    parameter int WORDS = wbs_pkg::WORDS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [2:0]                       i_op,
    input  logic signed [wbs_pkg::KEY_W-1:0] i_key,
    output logic                             o_valid,
    output logic [1:0]                       o_status,
    output logic                             o_answer,
    output logic signed [wbs_pkg::KEY_W-1:0] o_found_key
);
    import wbs_pkg::*;

    localparam int IW = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [IW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    wbs_seq #(
        .WORDS (WORDS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_op        (i_op),
        .i_key       (i_key),
        .o_busy      (busy),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_answer    (o_answer),
        .o_found_key (o_found_key),
        .o_we        (ram_we),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata),
        .o_raddr     (ram_raddr),
        .i_rdata     (ram_rdata)
    );

    wbs_ram #(
        .WORDS (WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule
